/* sv/schwarzschild_infall_rk4_step_core_defines.svh */
// Assertion macros for the infall stepper core.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef SCHWARZSCHILD_INFALL_RK4_STEP_CORE_DEFINES_SVH
`define SCHWARZSCHILD_INFALL_RK4_STEP_CORE_DEFINES_SVH
// same-cycle implication
`define SIFR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SIFR_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* sv/sifr_pkg.sv */
// Shared types, constants and tables for the infall stepper.
// No dependencies.
package sifr_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int DIV_NUM_W    = 48;
  localparam int DIV_DEN_W    = 31;
  localparam int SQRT_STEPS   = 32;
  localparam int CORD_W       = 36;
  localparam int ZW           = 34;

  localparam logic [30:0] QCAP         = 31'h7FFF_FFFF;
  localparam logic [31:0] K_CAP        = 32'h8000_0000;
  localparam logic [31:0] TURN_PER_RAD = 32'd683565276;
  localparam logic [31:0] INV_GAIN_Q30 = 32'd652032874;
  localparam logic [16:0] ONE_Q        = 17'h1_0000;
  localparam logic signed [ZW-1:0] Z_QUARTER = 34'sh0_4000_0000;
  localparam logic signed [ZW-1:0] Z_HALF    = 34'sh0_8000_0000;

  // 2^20 = 6 * DIV6_HI + 4; DIV6_RCP = ceil(2^25 / 6), exact below 2^22
  localparam logic [17:0] DIV6_HI  = 18'd174762;
  localparam logic [22:0] DIV6_RCP = 23'd5592406;

  localparam logic       CMD_ADVANCE = 1'b0;
  localparam logic       CMD_RELOAD  = 1'b1;

  localparam logic [2:0] REG_HORIZON = 3'd0;
  localparam logic [2:0] REG_START_R = 3'd1;
  localparam logic [2:0] REG_START_A = 3'd2;
  localparam logic [2:0] REG_ENERGY  = 3'd3;
  localparam logic [2:0] REG_ANG_MOM = 3'd4;
  localparam logic [2:0] REG_SCALE   = 3'd5;

  typedef enum logic [4:0] {
    ST_IDLE, ST_E2, ST_E2W, ST_EV_A, ST_EV_AW, ST_EV_QW, ST_EV_B, ST_EV_BW,
    ST_EV_P, ST_EV_T, ST_EV_SW, ST_MID, ST_MIDW, ST_SUM, ST_SUMD, ST_SUMQ,
    ST_SUMW, ST_W1, ST_W1W, ST_W2, ST_W2W, ST_R1, ST_R2, ST_R3, ST_R4, ST_R5,
    ST_PL1, ST_PL2, ST_PL3, ST_PL4, ST_PLW, ST_OUT
  } state_e;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic [30:0] sat31(input logic [DIV_NUM_W-1:0] v);
    return (v > {17'd0, QCAP}) ? QCAP : v[30:0];
  endfunction

endpackage

/* sv/sifr_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on sifr_pkg.
module sifr_div import sifr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIV_NUM_W-1:0] num_i,
  input  logic [DIV_DEN_W-1:0] den_i,
  output logic                 done_o,
  output logic [DIV_NUM_W-1:0] quot_o
);
  localparam int CW = $clog2(DIV_NUM_W);

  logic                 busy_q, done_q;
  logic [CW-1:0]        cnt_q;
  logic [DIV_NUM_W-1:0] n_q;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_DEN_W:0]   rem_q, tmp;
  logic                 qbit;

  assign tmp  = {rem_q[DIV_DEN_W-1:0], n_q[DIV_NUM_W-1]};
  assign qbit = (tmp >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CW'(DIV_NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= qbit ? (tmp - {1'b0, den_q}) : tmp;
      n_q   <= {n_q[DIV_NUM_W-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quot_o = n_q;
endmodule

/* sv/sifr_sqrt.sv */
// Floor integer square root of a 64-bit word, two bits per cycle.
// Depends on sifr_pkg.
module sifr_sqrt import sifr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] n_i,
  output logic        done_o,
  output logic [31:0] root_o
);
  localparam int CW = $clog2(SQRT_STEPS);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [63:0]   n_q;
  logic [35:0]   rem_q, tmp, trial;
  logic [31:0]   root_q;
  logic          bit_ok;

  assign tmp    = {rem_q[33:0], n_q[63:62]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign bit_ok = (tmp >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CW'(SQRT_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q    <= n_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rem_q  <= bit_ok ? (tmp - trial) : tmp;
      root_q <= {root_q[30:0], bit_ok};
      n_q    <= {n_q[61:0], 2'b00};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule

/* sv/sifr_cordic.sv */
// Rotation-mode CORDIC, one micro-rotation per cycle.
// Depends on sifr_pkg (arctangent table, widths).
module sifr_cordic import sifr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [CORD_W-1:0] x0_i,
  input  logic signed [ZW-1:0]     z0_i,
  output logic                     done_o,
  output logic signed [CORD_W-1:0] x_o,
  output logic signed [CORD_W-1:0] y_o
);
  localparam int CW = $clog2(CORDIC_STEPS + 1);

  logic                     busy_q, done_q;
  logic [CW-1:0]            i_q;
  logic signed [CORD_W-1:0] x_q, y_q, xs, ys;
  logic signed [ZW-1:0]     z_q, at;

  assign xs = x_q >>> i_q;
  assign ys = y_q >>> i_q;
  assign at = $signed({2'b00, atan_turn(5'(i_q))});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        i_q    <= '0;
      end else if (busy_q) begin
        if (i_q == CW'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        i_q <= i_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= x0_i;
      y_q <= '0;
      z_q <= z0_i;
    end else if (busy_q) begin
      if (!z_q[ZW-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
    end
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
endmodule

/* sv/schwarzschild_infall_rk4_step_core.sv */
// Advance step: the time from accept to result is set by ten divider passes,
// four roots and a CORDIC; quotients forced to saturation skip their divider
// pass, and a crossing step skips placement.
// One word in flight; the next word is accepted the cycle after the result
// loads, and an untaken result holds the next one in its last state.
// Reset (async, active low) loads default registers and the start particle.
`include "schwarzschild_infall_rk4_step_core_defines.svh"
module schwarzschild_infall_rk4_step_core import sifr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               command_i,
  input  logic [19:0]        time_step_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic [30:0]        radius_out_o,
  output logic signed [31:0] radial_rate_o,
  output logic [31:0]        angle_out_o,
  output logic               active_out_o,
  output logic               crossed_o,
  output logic               guarded_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i
);

  state_e state_q, state_d;

  logic [23:0] hr_q, lm_q;
  logic [30:0] sr_q;
  logic [31:0] sa_q;
  logic [17:0] en_q;
  logic [15:0] ws_q;

  logic [30:0] r_q, r_d;
  logic [31:0] ang_q, ang_d;
  logic        act_q, act_d;
  logic signed [15:0] lx_q, lx_d, ly_q, ly_d;

  logic [19:0] dt_q, dt_d;
  logic        guard_q, guard_d, cross_q, cross_d;
  logic [31:0] rate_q, rate_d;
  logic [20:0] e2_q, e2_d;
  logic signed [40:0] rc_q, rc_d;
  logic [30:0] a_q, a_d, q_q, q_d, b_q, b_d, rn_q, rn_d, w_q, w_d, s_q, s_d;
  logic [31:0] k_q [4];
  logic [31:0] k_d [4];
  logic [1:0]  kidx_q, kidx_d;
  logic [34:0] rad_q, rad_d;
  logic [31:0] hi_q, hi_d;
  logic [21:0] xr_q, xr_d;
  logic [36:0] qh_q, qh_d;
  logic [67:0] mp_q;
  logic [35:0] mul_a;
  logic [31:0] mul_b;

  logic        ov_q, ov_d, out_load;

  logic                 div_start, div_done;
  logic [DIV_NUM_W-1:0] div_num, div_quot;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 sq_start, sq_done;
  logic [63:0]          sq_n;
  logic [31:0]          sq_root;
  logic                 cor_start, cor_done;
  logic signed [CORD_W-1:0] cor_x0, cor_x, cor_y;
  logic signed [ZW-1:0]     cor_z0;

  logic        rc_pos, f1_neg;
  logic [31:0] absf, kv, kcur;
  logic [34:0] ksum;
  logic [37:0] q6;
  logic signed [49:0] term_s, rn_s;
  logic [35:0] off;
  logic [30:0] s2;
  logic signed [ZW-1:0] zs;
  logic signed [15:0] xq, yq;

  sifr_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quot_o(div_quot)
  );

  sifr_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .n_i(sq_n), .done_o(sq_done), .root_o(sq_root)
  );

  sifr_cordic u_cordic (
    .clk_i, .rst_ni, .start_i(cor_start), .x0_i(cor_x0), .z0_i(cor_z0),
    .done_o(cor_done), .x_o(cor_x), .y_o(cor_y)
  );

  function automatic logic signed [15:0] to_q13(input logic signed [CORD_W-1:0] v);
    logic signed [CORD_W-1:0] t;
    t = v >>> 3;
    if (t > 36'sd32767) return 16'sh7FFF;
    if (t < -36'sd32768) return 16'sh8000;
    return t[15:0];
  endfunction

  assign rc_pos = !rc_q[40] && (rc_q != '0);
  assign f1_neg = ({1'b0, a_q} > {15'd0, ONE_Q});
  assign absf   = f1_neg ? ({1'b0, a_q} - {15'd0, ONE_Q}) : ({15'd0, ONE_Q} - {1'b0, a_q});
  assign kv     = (sq_root > K_CAP) ? K_CAP : sq_root;
  assign kcur   = k_q[kidx_q];
  assign ksum   = {3'd0, k_q[0]} + {2'd0, k_q[1], 1'b0} + {2'd0, k_q[2], 1'b0}
                + {3'd0, k_q[3]};
  assign term_s = f1_neg ? ($signed({29'd0, e2_q}) + $signed({2'd0, mp_q[63:16]}))
                         : ($signed({29'd0, e2_q}) - $signed({2'd0, mp_q[63:16]}));
  assign off    = (kidx_q == 2'd2) ? mp_q[51:16] : mp_q[52:17];
  assign q6     = {1'b0, qh_q} + {18'd0, mp_q[44:25]};
  assign rn_s   = $signed({19'd0, r_q}) - $signed({12'd0, q6});
  assign s2     = mp_q[60:30];
  assign xq     = to_q13(cor_x);
  assign yq     = to_q13(cor_y);

  always_ff @(posedge clk_i) begin
    mp_q <= mul_a * mul_b;
  end

  always_comb begin
    state_d   = state_q;
    r_d       = r_q;
    ang_d     = ang_q;
    act_d     = act_q;
    lx_d      = lx_q;
    ly_d      = ly_q;
    dt_d      = dt_q;
    guard_d   = guard_q;
    cross_d   = cross_q;
    rate_d    = rate_q;
    e2_d      = e2_q;
    rc_d      = rc_q;
    a_d       = a_q;
    q_d       = q_q;
    b_d       = b_q;
    rn_d      = rn_q;
    w_d       = w_q;
    s_d       = s_q;
    k_d       = k_q;
    kidx_d    = kidx_q;
    rad_d     = rad_q;
    hi_d      = hi_q;
    xr_d      = xr_q;
    qh_d      = qh_q;
    ov_d      = ov_q & ~out_ready_i;
    out_load  = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    sq_start  = 1'b0;
    sq_n      = '0;
    cor_start = 1'b0;
    cor_x0    = '0;
    cor_z0    = '0;
    zs        = $signed({{2{ang_q[31]}}, ang_q});
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          dt_d    = time_step_i;
          guard_d = 1'b0;
          cross_d = 1'b0;
          rate_d  = '0;
          if (command_i == CMD_RELOAD) begin
            r_d     = sr_q;
            ang_d   = sa_q;
            act_d   = 1'b1;
            state_d = ST_PL1;
          end else if (act_q) begin
            kidx_d  = '0;
            rc_d    = $signed({10'd0, r_q});
            state_d = ST_E2;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_E2: begin
        mul_a   = {18'd0, en_q};
        mul_b   = {14'd0, en_q};
        state_d = ST_E2W;
      end
      ST_E2W: begin
        e2_d    = mp_q[36:16];
        state_d = ST_EV_A;
      end
      ST_EV_A: begin
        if (!rc_pos) begin
          a_d     = QCAP;
          q_d     = QCAP;
          guard_d = 1'b1;
          state_d = ST_EV_B;
        end else begin
          div_start = 1'b1;
          div_num   = {8'd0, hr_q, 16'd0};
          div_den   = rc_q[30:0];
          state_d   = ST_EV_AW;
        end
      end
      ST_EV_AW: begin
        if (div_done) begin
          a_d       = sat31(div_quot);
          div_start = 1'b1;
          div_num   = {8'd0, lm_q, 16'd0};
          div_den   = rc_q[30:0];
          state_d   = ST_EV_QW;
        end
      end
      ST_EV_QW: begin
        if (div_done) begin
          q_d     = sat31(div_quot);
          state_d = ST_EV_B;
        end
      end
      ST_EV_B: begin
        mul_a   = {5'd0, q_q};
        mul_b   = {1'b0, q_q};
        state_d = ST_EV_BW;
      end
      ST_EV_BW: begin
        b_d     = (mp_q[67:16] > {21'd0, QCAP}) ? QCAP : mp_q[46:16];
        state_d = ST_EV_P;
      end
      ST_EV_P: begin
        mul_a   = {4'd0, absf};
        mul_b   = {1'b0, b_q} + {15'd0, ONE_Q};
        state_d = ST_EV_T;
      end
      ST_EV_T: begin
        sq_start = 1'b1;
        sq_n     = term_s[49] ? 64'd0 : {term_s[47:0], 16'd0};
        state_d  = ST_EV_SW;
      end
      ST_EV_SW: begin
        if (sq_done) begin
          k_d[kidx_q] = kv;
          if (kidx_q == 2'd0) rate_d = ~kv + 32'd1;
          state_d = (kidx_q == 2'd3) ? ST_SUM : ST_MID;
        end
      end
      ST_MID: begin
        mul_a   = {4'd0, kcur};
        mul_b   = {12'd0, dt_q};
        state_d = ST_MIDW;
      end
      ST_MIDW: begin
        rc_d    = $signed({10'd0, r_q}) - $signed({5'd0, off});
        kidx_d  = kidx_q + 2'd1;
        state_d = ST_EV_A;
      end
      ST_SUM: begin
        mul_a   = {1'b0, ksum};
        mul_b   = {12'd0, dt_q};
        state_d = ST_SUMD;
      end
      ST_SUMD: begin
        xr_d    = {1'b0, mp_q[54:36], 2'b00} + {2'd0, mp_q[35:16]};
        mul_a   = {17'd0, mp_q[54:36]};
        mul_b   = {14'd0, DIV6_HI};
        state_d = ST_SUMQ;
      end
      ST_SUMQ: begin
        qh_d    = mp_q[36:0];
        mul_a   = {14'd0, xr_q};
        mul_b   = {9'd0, DIV6_RCP};
        state_d = ST_SUMW;
      end
      ST_SUMW: begin
        rn_d    = rn_s[49] ? 31'd0 : rn_s[30:0];
        state_d = ST_W1;
      end
      ST_W1: begin
        if (rn_q == '0) begin
          guard_d = 1'b1;
          w_d     = QCAP;
          state_d = ST_W2;
        end else begin
          div_start = 1'b1;
          div_num   = {8'd0, lm_q, 16'd0};
          div_den   = rn_q;
          state_d   = ST_W1W;
        end
      end
      ST_W1W: begin
        if (div_done) begin
          w_d     = sat31(div_quot);
          state_d = ST_W2;
        end
      end
      ST_W2: begin
        if (rn_q == '0) begin
          guard_d = 1'b1;
          w_d     = QCAP;
          state_d = ST_R1;
        end else begin
          div_start = 1'b1;
          div_num   = {1'b0, w_q, 16'd0};
          div_den   = rn_q;
          state_d   = ST_W2W;
        end
      end
      ST_W2W: begin
        if (div_done) begin
          w_d     = sat31(div_quot);
          state_d = ST_R1;
        end
      end
      ST_R1: begin
        mul_a   = {5'd0, w_q};
        mul_b   = {12'd0, dt_q};
        state_d = ST_R2;
      end
      ST_R2: begin
        rad_d   = mp_q[50:16];
        state_d = ST_R3;
      end
      ST_R3: begin
        mul_a   = {17'd0, rad_q[34:16]};
        mul_b   = TURN_PER_RAD;
        state_d = ST_R4;
      end
      ST_R4: begin
        hi_d    = mp_q[31:0];
        mul_a   = {20'd0, rad_q[15:0]};
        mul_b   = TURN_PER_RAD;
        state_d = ST_R5;
      end
      ST_R5: begin
        ang_d = ang_q + hi_q + mp_q[47:16];
        r_d   = rn_q;
        if (rn_q <= {7'd0, hr_q}) begin
          act_d   = 1'b0;
          cross_d = 1'b1;
          state_d = ST_OUT;
        end else begin
          state_d = ST_PL1;
        end
      end
      ST_PL1: begin
        mul_a   = {5'd0, r_q};
        mul_b   = {16'd0, ws_q};
        state_d = ST_PL2;
      end
      ST_PL2: begin
        s_d     = mp_q[46:16];
        state_d = ST_PL3;
      end
      ST_PL3: begin
        mul_a   = {5'd0, s_q};
        mul_b   = INV_GAIN_Q30;
        state_d = ST_PL4;
      end
      ST_PL4: begin
        cor_start = 1'b1;
        cor_x0    = $signed({5'd0, s2});
        if (zs > Z_QUARTER) begin
          zs     = zs - Z_HALF;
          cor_x0 = -$signed({5'd0, s2});
        end else if (zs < -Z_QUARTER) begin
          zs     = zs + Z_HALF;
          cor_x0 = -$signed({5'd0, s2});
        end
        cor_z0  = zs;
        state_d = ST_PLW;
      end
      ST_PLW: begin
        if (cor_done) begin
          lx_d    = xq;
          ly_d    = yq;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ov_q || out_ready_i) begin
          ov_d     = 1'b1;
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      r_q     <= 31'd1572864;
      ang_q   <= 32'd1610612736;
      act_q   <= 1'b1;
      lx_q    <= '0;
      ly_q    <= '0;
      ov_q    <= 1'b0;
      kidx_q  <= '0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      ang_q   <= ang_d;
      act_q   <= act_d;
      lx_q    <= lx_d;
      ly_q    <= ly_d;
      ov_q    <= ov_d;
      kidx_q  <= kidx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dt_q    <= dt_d;
    guard_q <= guard_d;
    cross_q <= cross_d;
    rate_q  <= rate_d;
    e2_q    <= e2_d;
    rc_q    <= rc_d;
    a_q     <= a_d;
    q_q     <= q_d;
    b_q     <= b_d;
    rn_q    <= rn_d;
    w_q     <= w_d;
    s_q     <= s_d;
    k_q     <= k_d;
    rad_q   <= rad_d;
    hi_q    <= hi_d;
    xr_q    <= xr_d;
    qh_q    <= qh_d;
    if (out_load) begin
      pos_x_o       <= lx_q;
      pos_y_o       <= ly_q;
      radius_out_o  <= r_q;
      radial_rate_o <= rate_q;
      angle_out_o   <= ang_q;
      active_out_o  <= act_q;
      crossed_o     <= cross_q;
      guarded_o     <= guard_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hr_q <= 24'd131072;
      sr_q <= 31'd1572864;
      sa_q <= 32'd1610612736;
      en_q <= 18'd65536;
      lm_q <= 24'd262144;
      ws_q <= 16'd3277;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HORIZON: hr_q <= cfg_wdata_i[23:0];
        REG_START_R: sr_q <= cfg_wdata_i[30:0];
        REG_START_A: sa_q <= cfg_wdata_i;
        REG_ENERGY:  en_q <= cfg_wdata_i[17:0];
        REG_ANG_MOM: lm_q <= cfg_wdata_i[23:0];
        REG_SCALE:   ws_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = ov_q;

  `SIFR_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, state_q != ST_IDLE, "word accepted but sequencer stayed idle")
  `SIFR_ASSERT_IMP(a_rate_nonpos, out_valid_o, radial_rate_o[31] || (radial_rate_o == '0), "positive radial rate")
  `SIFR_ASSERT_IMP(a_cross_inactive, out_valid_o && crossed_o, !active_out_o, "crossed word still active")

endmodule
